/* sv/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg
// Shared widths, codes and types for the seat pressure posture monitor.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Width of one pressure reading
  localparam int SAMPLE_BITS = 12;
  // Width of left + right
  localparam int SUM_W       = SAMPLE_BITS + 1;

  // Configuration register widths
  localparam int LEVEL_THR_W = 12;
  localparam int SIDE_MIN_W  = 13;
  localparam int PCT_W       = 7;
  localparam int MS_W        = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  // Balance test widths
  localparam int TOT_W  = (SUM_W > SIDE_MIN_W) ? SUM_W : SIDE_MIN_W;
  localparam int HUND_W = 7;
  localparam int PROD_W = ((SUM_W + PCT_W) > (SAMPLE_BITS + HUND_W)) ?
                          (SUM_W + PCT_W) : (SAMPLE_BITS + HUND_W);
  localparam logic [HUND_W-1:0] HUNDRED = HUND_W'(100);

  // Millisecond / second split of the timers
  localparam int MS_PER_SEC = 1000;
  localparam int FRAC_W     = $clog2(MS_PER_SEC);
  localparam int SEC_W      = 23;
  localparam int POSTURE_W  = 3;

  // Input action codes
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEAT_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMBAR_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_PCT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIT_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INT  = 3'd6;

  // Register reset values
  localparam logic [LEVEL_THR_W-1:0] RST_SEAT_THR    = 12'd1000;
  localparam logic [LEVEL_THR_W-1:0] RST_LUMBAR_THR  = 12'd2500;
  localparam logic [SIDE_MIN_W-1:0]  RST_SIDE_MIN    = 13'd800;
  localparam logic [PCT_W-1:0]       RST_BALANCE_PCT = 7'd40;
  localparam logic [MS_W-1:0]        RST_BAD_LIMIT   = 32'd30000;
  localparam logic [MS_W-1:0]        RST_SIT_LIMIT   = 32'd120000;
  localparam logic [MS_W-1:0]        RST_REPORT_INT  = 32'd15000;

  // Posture classes
  typedef enum logic [POSTURE_W-1:0] {
    P_EMPTY     = 3'd0,
    P_GOOD      = 3'd1,
    P_LEFT      = 3'd2,
    P_RIGHT     = 3'd3,
    P_NOLUMBAR  = 3'd4,
    P_UNCERTAIN = 3'd5
  } posture_e;

  // Configuration register set
  typedef struct packed {
    logic [LEVEL_THR_W-1:0] seat_thr;
    logic [LEVEL_THR_W-1:0] lumbar_thr;
    logic [SIDE_MIN_W-1:0]  side_min;
    logic [PCT_W-1:0]       balance_pct;
    logic [MS_W-1:0]        bad_limit;
    logic [MS_W-1:0]        sit_limit;
    logic [MS_W-1:0]        report_int;
  } cfg_t;

  // One registered input item
  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] seat;
    logic [SAMPLE_BITS-1:0] lumbar;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } in_item_t;

endpackage

/* sv/spm_in_if.sv */
// ----------------------------------------------------------------------------
// spm_in_if
// Input channel: a tick or a pressure sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [spm_pkg::SAMPLE_BITS-1:0] seat_level;
  logic [spm_pkg::SAMPLE_BITS-1:0] lumbar_level;
  logic [spm_pkg::SAMPLE_BITS-1:0] left_level;
  logic [spm_pkg::SAMPLE_BITS-1:0] right_level;

  modport source (
    output valid, action, seat_level, lumbar_level, left_level, right_level,
    input  ready
  );
  modport sink (
    input  valid, action, seat_level, lumbar_level, left_level, right_level,
    output ready
  );
endinterface

/* sv/spm_out_if.sv */
// ----------------------------------------------------------------------------
// spm_out_if
// Report channel: one posture report per sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spm_out_if;
  logic                          valid;
  logic                          ready;
  logic [spm_pkg::POSTURE_W-1:0] posture;
  logic [spm_pkg::SEC_W-1:0]     sitting_seconds;
  logic [spm_pkg::SEC_W-1:0]     bad_seconds;
  logic                          posture_alert;
  logic                          sitting_alert;
  logic                          send_now;

  modport source (
    output valid, posture, sitting_seconds, bad_seconds, posture_alert,
           sitting_alert, send_now,
    input  ready
  );
  modport sink (
    input  valid, posture, sitting_seconds, bad_seconds, posture_alert,
           sitting_alert, send_now,
    output ready
  );
endinterface

/* sv/spm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// spm_cfg_regs
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module spm_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output spm_pkg::cfg_t                      cfg_o
);

  spm_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index and update one register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spm_pkg::CFG_SEAT_THR:
          cfg_d.seat_thr    = cfg_data_i[spm_pkg::LEVEL_THR_W-1:0];
        spm_pkg::CFG_LUMBAR_THR:
          cfg_d.lumbar_thr  = cfg_data_i[spm_pkg::LEVEL_THR_W-1:0];
        spm_pkg::CFG_SIDE_MIN:
          cfg_d.side_min    = cfg_data_i[spm_pkg::SIDE_MIN_W-1:0];
        spm_pkg::CFG_BALANCE_PCT:
          cfg_d.balance_pct = cfg_data_i[spm_pkg::PCT_W-1:0];
        spm_pkg::CFG_BAD_LIMIT:
          cfg_d.bad_limit   = cfg_data_i[spm_pkg::MS_W-1:0];
        spm_pkg::CFG_SIT_LIMIT:
          cfg_d.sit_limit   = cfg_data_i[spm_pkg::MS_W-1:0];
        spm_pkg::CFG_REPORT_INT:
          cfg_d.report_int  = cfg_data_i[spm_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seat_thr    <= spm_pkg::RST_SEAT_THR;
      cfg_q.lumbar_thr  <= spm_pkg::RST_LUMBAR_THR;
      cfg_q.side_min    <= spm_pkg::RST_SIDE_MIN;
      cfg_q.balance_pct <= spm_pkg::RST_BALANCE_PCT;
      cfg_q.bad_limit   <= spm_pkg::RST_BAD_LIMIT;
      cfg_q.sit_limit   <= spm_pkg::RST_SIT_LIMIT;
      cfg_q.report_int  <= spm_pkg::RST_REPORT_INT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/spm_classify.sv */
// ----------------------------------------------------------------------------
// spm_classify
// Sorts one pressure sample into a posture class.
// ----------------------------------------------------------------------------
module spm_classify (
  input  spm_pkg::in_item_t  item_i,
  input  spm_pkg::cfg_t      cfg_i,
  output spm_pkg::posture_e  posture_o
);

  logic [spm_pkg::SUM_W-1:0]       total;
  logic [spm_pkg::SAMPLE_BITS-1:0] diff;
  logic                            left_heavy;
  logic                            right_heavy;
  logic [spm_pkg::PROD_W-1:0]      lhs;
  logic [spm_pkg::PROD_W-1:0]      rhs;
  logic                            below_seat;
  logic                            below_lumbar;
  logic                            below_side;

  // Side sums and the absolute side difference
  assign total       = spm_pkg::SUM_W'(item_i.left) + spm_pkg::SUM_W'(item_i.right);
  assign left_heavy  = item_i.left > item_i.right;
  assign right_heavy = item_i.right > item_i.left;
  assign diff        = left_heavy ? (item_i.left - item_i.right)
                                  : (item_i.right - item_i.left);

  // Imbalance test: 100 * |l - r| against pct * (l + r)
  assign lhs = spm_pkg::PROD_W'(diff) * spm_pkg::PROD_W'(spm_pkg::HUNDRED);
  assign rhs = spm_pkg::PROD_W'(cfg_i.balance_pct) * spm_pkg::PROD_W'(total);

  // Threshold compares
  assign below_seat   = item_i.seat < cfg_i.seat_thr;
  assign below_lumbar = item_i.lumbar < cfg_i.lumbar_thr;
  assign below_side   = spm_pkg::TOT_W'(total) < spm_pkg::TOT_W'(cfg_i.side_min);

  // Priority order of the classes
  always_comb begin
    if (below_seat) begin
      posture_o = spm_pkg::P_EMPTY;
    end else if (below_lumbar) begin
      posture_o = spm_pkg::P_NOLUMBAR;
    end else if (below_side) begin
      posture_o = spm_pkg::P_UNCERTAIN;
    end else if (left_heavy && (lhs > rhs)) begin
      posture_o = spm_pkg::P_LEFT;
    end else if (right_heavy && (lhs > rhs)) begin
      posture_o = spm_pkg::P_RIGHT;
    end else begin
      posture_o = spm_pkg::P_GOOD;
    end
  end

endmodule

/* sv/spm_timer.sv */
// ----------------------------------------------------------------------------
// spm_timer
// Saturating millisecond timer that also keeps whole seconds.
// ----------------------------------------------------------------------------
module spm_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        inc_i,
  input  logic                        clr_i,
  output logic [spm_pkg::MS_W-1:0]    ms_o,
  output logic [spm_pkg::SEC_W-1:0]   sec_o
);

  localparam logic [spm_pkg::FRAC_W-1:0] FRAC_LAST =
    spm_pkg::FRAC_W'(spm_pkg::MS_PER_SEC - 1);

  logic [spm_pkg::MS_W-1:0]   ms_q, ms_d;
  logic [spm_pkg::FRAC_W-1:0] frac_q, frac_d;
  logic [spm_pkg::SEC_W-1:0]  sec_q, sec_d;
  logic                       sat;

  assign sat = &ms_q;

  // Clear, or advance ms and roll the sub-second count into seconds
  always_comb begin
    ms_d   = ms_q;
    frac_d = frac_q;
    sec_d  = sec_q;
    if (clr_i) begin
      ms_d   = '0;
      frac_d = '0;
      sec_d  = '0;
    end else if (inc_i && !sat) begin
      ms_d = ms_q + 1'b1;
      if (frac_q == FRAC_LAST) begin
        frac_d = '0;
        sec_d  = sec_q + 1'b1;
      end else begin
        frac_d = frac_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q   <= '0;
      frac_q <= '0;
      sec_q  <= '0;
    end else begin
      ms_q   <= ms_d;
      frac_q <= frac_d;
      sec_q  <= sec_d;
    end
  end

  assign ms_o  = ms_q;
  assign sec_o = sec_q;

endmodule

/* sv/seat_pressure_posture_monitor_unit.sv */
// ----------------------------------------------------------------------------
// seat_pressure_posture_monitor_unit
// Posture classifier with sitting / bad-posture timers and alert reporting.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries either a one-millisecond tick (action = 0) or a sample of
//          seat, lumbar, left and right pressure (action = 1).
//   out_o  carries one report per sample: posture class, sitting and bad
//          posture seconds, both alert flags and the send-now flag. Ticks
//          produce no report.
//   cfg_*  write-only register port; write only while the block is idle.
// Timing:
//   An item is held in the input register, then updates the state; a sample
//   also loads the report register, so out_o.valid rises once the sample moves
//   from the input register into the report register.
//   One item per cycle is sustained unless a sample waits behind a stalled
//   report; the single path from input to report register sets that figure.
// Stall:
//   While a report waits, ticks keep flowing; a sample waits in the input
//   register and in_i.ready drops only while that sample sits behind the
//   waiting report.
// Reset:
//   Timers, flags and occupancy clear; registers take their default values.
// ----------------------------------------------------------------------------
module seat_pressure_posture_monitor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spm_in_if.sink                          in_i,
  spm_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  spm_pkg::cfg_t      cfg;
  spm_pkg::in_item_t  in_q;
  spm_pkg::posture_e  posture;

  logic in_vld_q;
  logic out_vld_q;
  logic adv, tick_go, smp_go;

  logic occupied_q, occupied_d;
  logic bad_timing_q, bad_timing_d;
  logic pa_q, pa_d;
  logic sa_q, sa_d;
  logic [spm_pkg::MS_W-1:0] since_q, since_d;

  logic sit_clr, bad_clr;
  logic [spm_pkg::MS_W-1:0]  sit_ms, bad_ms;
  logic [spm_pkg::SEC_W-1:0] sit_sec, bad_sec;

  logic [spm_pkg::SEC_W-1:0] sit_s, bad_s;
  logic                      send;

  logic [spm_pkg::POSTURE_W-1:0] posture_q;
  logic [spm_pkg::SEC_W-1:0]     sit_s_q, bad_s_q;
  logic                          pa_out_q, sa_out_q, send_q;

  // Configuration registers
  spm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance when the item is a tick or the report register can take a report
  assign adv     = in_vld_q && ((in_q.action == spm_pkg::ACT_TICK) ||
                                !out_vld_q || out_o.ready);
  assign tick_go = adv && (in_q.action == spm_pkg::ACT_TICK);
  assign smp_go  = adv && (in_q.action == spm_pkg::ACT_SAMPLE);
  assign in_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.action <= in_i.action;
      in_q.seat   <= in_i.seat_level;
      in_q.lumbar <= in_i.lumbar_level;
      in_q.left   <= in_i.left_level;
      in_q.right  <= in_i.right_level;
    end
  end

  // Posture class of the held sample
  spm_classify u_cls (
    .item_i    (in_q),
    .cfg_i     (cfg),
    .posture_o (posture)
  );

  // Sitting and bad-posture timers
  spm_timer u_sit_tmr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inc_i  (tick_go && occupied_q),
    .clr_i  (sit_clr),
    .ms_o   (sit_ms),
    .sec_o  (sit_sec)
  );

  spm_timer u_bad_tmr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inc_i  (tick_go && bad_timing_q),
    .clr_i  (bad_clr),
    .ms_o   (bad_ms),
    .sec_o  (bad_sec)
  );

  // Session state update for one tick or sample
  always_comb begin
    logic                     sit_down;
    logic                     evt;
    logic                     pa_v, sa_v, bt_v;
    logic [spm_pkg::MS_W-1:0] sit_ms_v, bad_ms_v;

    occupied_d   = occupied_q;
    bad_timing_d = bad_timing_q;
    pa_d         = pa_q;
    sa_d         = sa_q;
    since_d      = since_q;
    sit_clr      = 1'b0;
    bad_clr      = 1'b0;
    sit_s        = '0;
    bad_s        = '0;
    send         = 1'b0;
    evt          = 1'b0;
    sit_down     = !occupied_q;
    pa_v         = sit_down ? 1'b0 : pa_q;
    sa_v         = sit_down ? 1'b0 : sa_q;
    bt_v         = sit_down ? 1'b0 : bad_timing_q;
    sit_ms_v     = sit_down ? '0 : sit_ms;
    bad_ms_v     = bt_v ? bad_ms : '0;

    if (tick_go) begin
      // Free-running report interval, saturating
      if (!(&since_q)) begin
        since_d = since_q + 1'b1;
      end
    end else if (smp_go) begin
      if (posture == spm_pkg::P_EMPTY) begin
        // Stand up ends the session
        if (occupied_q) begin
          occupied_d   = 1'b0;
          bad_timing_d = 1'b0;
          pa_d         = 1'b0;
          sa_d         = 1'b0;
          sit_clr      = 1'b1;
          bad_clr      = 1'b1;
          evt          = 1'b1;
        end
      end else begin
        // Sit down starts a fresh session
        occupied_d = 1'b1;
        if (sit_down) begin
          sit_clr = 1'b1;
          bad_clr = 1'b1;
          evt     = 1'b1;
        end
        sit_s = sit_down ? '0 : sit_sec;
        sa_d  = sa_v;
        if (!sa_v && (sit_ms_v >= cfg.sit_limit)) begin
          sa_d = 1'b1;
          evt  = 1'b1;
        end
        if (posture == spm_pkg::P_GOOD) begin
          bad_timing_d = 1'b0;
          bad_clr      = 1'b1;
          pa_d         = 1'b0;
          if (pa_v) begin
            evt = 1'b1;
          end
        end else begin
          bad_timing_d = 1'b1;
          if (!bt_v) begin
            bad_clr = 1'b1;
          end
          bad_s = bt_v ? bad_sec : '0;
          pa_d  = pa_v;
          if (!pa_v && (bad_ms_v >= cfg.bad_limit)) begin
            pa_d = 1'b1;
            evt  = 1'b1;
          end
        end
      end
      // Report on an event or when the routine interval has run out
      if (evt || (since_q >= cfg.report_int)) begin
        send    = 1'b1;
        since_d = '0;
      end
    end
  end

  // Session state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied_q   <= 1'b0;
      bad_timing_q <= 1'b0;
      pa_q         <= 1'b0;
      sa_q         <= 1'b0;
      since_q      <= '0;
    end else begin
      occupied_q   <= occupied_d;
      bad_timing_q <= bad_timing_d;
      pa_q         <= pa_d;
      sa_q         <= sa_d;
      since_q      <= since_d;
    end
  end

  // Report register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (smp_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Report register payload
  always_ff @(posedge clk_i) begin
    if (smp_go) begin
      posture_q <= posture;
      sit_s_q   <= sit_s;
      bad_s_q   <= bad_s;
      pa_out_q  <= pa_d;
      sa_out_q  <= sa_d;
      send_q    <= send;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.posture         = posture_q;
  assign out_o.sitting_seconds = sit_s_q;
  assign out_o.bad_seconds     = bad_s_q;
  assign out_o.posture_alert   = pa_out_q;
  assign out_o.sitting_alert   = sa_out_q;
  assign out_o.send_now        = send_q;

endmodule

/* sv/spm_checker.sv */
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks on the posture reports, bound to the top level.
// ----------------------------------------------------------------------------
module spm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [spm_pkg::POSTURE_W-1:0] posture_i,
  input  logic [spm_pkg::SEC_W-1:0]     sitting_seconds_i,
  input  logic [spm_pkg::SEC_W-1:0]     bad_seconds_i,
  input  logic                          posture_alert_i,
  input  logic                          sitting_alert_i
);

  // Hold a stalled report
  a_stall_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(posture_i) && $stable(sitting_seconds_i) &&
       $stable(bad_seconds_i))
  ) else $error("report changed while stalled");

  // Empty chair reports no time and no alerts
  a_empty_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (posture_i == spm_pkg::P_EMPTY)) |->
      ((sitting_seconds_i == '0) && (bad_seconds_i == '0) &&
       !posture_alert_i && !sitting_alert_i)
  ) else $error("empty report carries session data");

  // Good posture drops the bad timer and the posture alert
  a_good_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (posture_i == spm_pkg::P_GOOD)) |->
      ((bad_seconds_i == '0) && !posture_alert_i)
  ) else $error("good report carries bad posture data");

  // Bad seconds never run ahead of sitting seconds
  a_bad_le_sit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (bad_seconds_i <= sitting_seconds_i)
  ) else $error("bad posture time exceeds sitting time");

endmodule

bind seat_pressure_posture_monitor_unit spm_checker u_spm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .posture_i         (out_o.posture),
  .sitting_seconds_i (out_o.sitting_seconds),
  .bad_seconds_i     (out_o.bad_seconds),
  .posture_alert_i   (out_o.posture_alert),
  .sitting_alert_i   (out_o.sitting_alert)
);

/* sim/seat_pressure_posture_monitor_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seat_pressure_posture_monitor_unit_checker
// Watches the tick/sample channel, the report channel and the register port,
// runs its own posture and timer model on every input transfer, and compares
// each report transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module seat_pressure_posture_monitor_unit_checker
  import spm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spm_in_if                     in_mon,
  spm_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           reports_due_o,
  output int unsigned           mismatches_o
);

  typedef struct packed {
    posture_e         posture;
    logic [SEC_W-1:0] sitting_s;
    logic [SEC_W-1:0] bad_s;
    logic             posture_alert;
    logic             sitting_alert;
    logic             send_now;
  } report_t;

  // Model copy of registers and session state
  cfg_t            cfg;
  logic            occupied;
  logic            bad_running;
  logic            posture_alarm;
  logic            sitting_alarm;
  logic [MS_W-1:0] sit_ms;
  logic [MS_W-1:0] bad_ms;
  logic [MS_W-1:0] since_ms;
  report_t         due_reports[$];

  function automatic logic [MS_W-1:0] bump(input logic [MS_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Sort one sample into a posture class; all tests exact and strict
  function automatic posture_e sort_posture(input logic [SAMPLE_BITS-1:0] seat, lumbar,
                                            input logic [SAMPLE_BITS-1:0] lft, rgt);
    logic [31:0] total;
    logic [31:0] allowed;
    logic [31:0] tilt;
    total   = 32'(lft) + 32'(rgt);
    allowed = 32'(cfg.balance_pct) * total;
    if (seat < cfg.seat_thr) return P_EMPTY;
    if (lumbar < cfg.lumbar_thr) return P_NOLUMBAR;
    if (total < 32'(cfg.side_min)) return P_UNCERTAIN;
    if (lft > rgt) begin
      tilt = 32'd100 * (32'(lft) - 32'(rgt));
      if (tilt > allowed) return P_LEFT;
    end else if (rgt > lft) begin
      tilt = 32'd100 * (32'(rgt) - 32'(lft));
      if (tilt > allowed) return P_RIGHT;
    end
    return P_GOOD;
  endfunction

  function automatic void clear_session();
    sit_ms        = '0;
    bad_running   = 1'b0;
    bad_ms        = '0;
    posture_alarm = 1'b0;
    sitting_alarm = 1'b0;
  endfunction

  // Advance all running timers by one millisecond
  function automatic void count_tick();
    if (occupied) sit_ms = bump(sit_ms);
    if (bad_running) bad_ms = bump(bad_ms);
    since_ms = bump(since_ms);
  endfunction

  // Update the session on a sample and build the report it causes
  function automatic report_t judge_sample(input logic [SAMPLE_BITS-1:0] seat, lumbar,
                                           input logic [SAMPLE_BITS-1:0] lft, rgt);
    posture_e cls;
    report_t  rep;
    logic     flagged;
    cls     = sort_posture(seat, lumbar, lft, rgt);
    flagged = 1'b0;
    rep     = '0;
    rep.posture = cls;
    if (cls == P_EMPTY) begin
      if (occupied) begin
        occupied = 1'b0;
        clear_session();
        flagged = 1'b1;
      end
    end else begin
      if (!occupied) begin
        occupied = 1'b1;
        clear_session();
        flagged = 1'b1;
      end
      rep.sitting_s = SEC_W'(sit_ms / MS_PER_SEC);
      if (!sitting_alarm && sit_ms >= cfg.sit_limit) begin
        sitting_alarm = 1'b1;
        flagged = 1'b1;
      end
      if (cls == P_GOOD) begin
        bad_running = 1'b0;
        bad_ms = '0;
        if (posture_alarm) begin
          posture_alarm = 1'b0;
          flagged = 1'b1;
        end
      end else begin
        // Switching between bad classes keeps the bad timer running
        if (!bad_running) begin
          bad_running = 1'b1;
          bad_ms = '0;
        end
        rep.bad_s = SEC_W'(bad_ms / MS_PER_SEC);
        if (!posture_alarm && bad_ms >= cfg.bad_limit) begin
          posture_alarm = 1'b1;
          flagged = 1'b1;
        end
      end
    end
    if (flagged || since_ms >= cfg.report_int) begin
      rep.send_now = 1'b1;
      since_ms = '0;
    end
    rep.posture_alert = posture_alarm;
    rep.sitting_alert = sitting_alarm;
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t want;
    if (!rst_ni) begin
      cfg.seat_thr    = RST_SEAT_THR;
      cfg.lumbar_thr  = RST_LUMBAR_THR;
      cfg.side_min    = RST_SIDE_MIN;
      cfg.balance_pct = RST_BALANCE_PCT;
      cfg.bad_limit   = RST_BAD_LIMIT;
      cfg.sit_limit   = RST_SIT_LIMIT;
      cfg.report_int  = RST_REPORT_INT;
      occupied = 1'b0;
      clear_session();
      since_ms = '0;
      due_reports.delete();
    end else begin
      // Compare a report transfer before queueing anything from this edge
      if (out_mon.valid && out_mon.ready) begin
        if (due_reports.size() == 0) begin
          $error("report transfer with no prediction pending: posture %0d",
                 out_mon.posture);
          mismatches_o++;
        end else begin
          want = due_reports.pop_front();
          check_field("posture", 32'(want.posture), 32'(out_mon.posture));
          check_field("sitting_seconds", 32'(want.sitting_s), 32'(out_mon.sitting_seconds));
          check_field("bad_seconds", 32'(want.bad_s), 32'(out_mon.bad_seconds));
          check_field("posture_alert", 32'(want.posture_alert), 32'(out_mon.posture_alert));
          check_field("sitting_alert", 32'(want.sitting_alert), 32'(out_mon.sitting_alert));
          check_field("send_now", 32'(want.send_now), 32'(out_mon.send_now));
        end
      end
      // Step the model on an input transfer
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_TICK) begin
          count_tick();
        end else begin
          due_reports.push_back(judge_sample(in_mon.seat_level, in_mon.lumbar_level,
                                             in_mon.left_level, in_mon.right_level));
        end
      end
      // Track register writes, masked to register widths
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEAT_THR:    cfg.seat_thr    = cfg_data_i[LEVEL_THR_W-1:0];
          CFG_LUMBAR_THR:  cfg.lumbar_thr  = cfg_data_i[LEVEL_THR_W-1:0];
          CFG_SIDE_MIN:    cfg.side_min    = cfg_data_i[SIDE_MIN_W-1:0];
          CFG_BALANCE_PCT: cfg.balance_pct = cfg_data_i[PCT_W-1:0];
          CFG_BAD_LIMIT:   cfg.bad_limit   = cfg_data_i[MS_W-1:0];
          CFG_SIT_LIMIT:   cfg.sit_limit   = cfg_data_i[MS_W-1:0];
          CFG_REPORT_INT:  cfg.report_int  = cfg_data_i[MS_W-1:0];
          default: ;
        endcase
      end
    end
    reports_due_o = due_reports.size();
  end

endmodule

/* sim/seat_pressure_posture_monitor_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seat_pressure_posture_monitor_unit_test
// Drives ticks and pressure samples through the posture monitor under several
// register settings, with random idling on both channels, a long report
// stall and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module seat_pressure_posture_monitor_unit_test;
  import spm_pkg::*;

  localparam int unsigned           TIMEOUT_CYCLES = 500000;
  localparam int unsigned           PHASES         = 7;
  localparam int unsigned           PHASE_ITEMS    = 140;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE      = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           reports_due;
  int unsigned           mismatches;
  int unsigned           cycles;
  bit                    calm;
  bit                    hold_reports;
  cfg_t                  cfg_now;

  spm_in_if  in_if ();
  spm_out_if out_if ();

  seat_pressure_posture_monitor_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  seat_pressure_posture_monitor_unit_checker report_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .reports_due_o (reports_due),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin : watchdog
    cycles = 0;
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL seat_pressure_posture_monitor_unit");
    $finish;
  end

  // Report receiver: random backpressure, one long hold-off on request
  initial begin : report_sink
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_reports) begin
        out_if.ready <= 1'b0;
        repeat (120) @(negedge clk_i);
        hold_reports = 1'b0;
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  // Offer one item and hold it until it transfers; call at a falling edge
  task automatic push_item(input logic act,
                           input logic [SAMPLE_BITS-1:0] seat, lumbar, lft, rgt);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < 14);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.seat_level   <= seat;
    in_if.lumbar_level <= lumbar;
    in_if.left_level   <= lft;
    in_if.right_level  <= rgt;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic push_ticks(input int unsigned count);
    repeat (count) push_item(ACT_TICK, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                             SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
  endtask

  // Aim readings at the current thresholds so most samples reach deep states
  task automatic pick_levels(output logic [SAMPLE_BITS-1:0] seat, lumbar, lft, rgt);
    int unsigned mode;
    int          base;
    int          l;
    int          r;
    mode = $urandom_range(0, 99);
    seat = SAMPLE_BITS'($urandom);
    lumbar = SAMPLE_BITS'($urandom);
    lft = SAMPLE_BITS'($urandom);
    rgt = SAMPLE_BITS'($urandom);
    if (mode < 10) return;
    if ($urandom_range(0, 99) < 12 && cfg_now.seat_thr != 0)
      seat = SAMPLE_BITS'($urandom_range(0, cfg_now.seat_thr - 1));
    else
      seat = SAMPLE_BITS'($urandom_range(cfg_now.seat_thr, 4095));
    if ($urandom_range(0, 99) < 15 && cfg_now.lumbar_thr != 0)
      lumbar = SAMPLE_BITS'($urandom_range(0, cfg_now.lumbar_thr - 1));
    else
      lumbar = SAMPLE_BITS'($urandom_range(cfg_now.lumbar_thr, 4095));
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      // Light side load, around the minimum total
      lft = SAMPLE_BITS'($urandom_range(0, 600));
      rgt = SAMPLE_BITS'($urandom_range(0, 600));
    end else if (mode < 55) begin
      // Roughly balanced
      base = $urandom_range(400, 3700);
      l = base;
      r = base + $urandom_range(0, 400) - 200;
      lft = SAMPLE_BITS'(l);
      rgt = SAMPLE_BITS'(r);
    end else if (mode < 80 && cfg_now.balance_pct < 100) begin
      // Right at the lean boundary, one side or the other
      r = $urandom_range(0, 2000);
      l = r * (100 + cfg_now.balance_pct) / (100 - cfg_now.balance_pct);
      l = l + $urandom_range(0, 2) - 1;
      if (l > 4095) l = 4095;
      if (l < 0) l = 0;
      if ($urandom_range(0, 1)) begin
        lft = SAMPLE_BITS'(l);
        rgt = SAMPLE_BITS'(r);
      end else begin
        lft = SAMPLE_BITS'(r);
        rgt = SAMPLE_BITS'(l);
      end
    end
  endtask

  task automatic push_sample();
    logic [SAMPLE_BITS-1:0] seat;
    logic [SAMPLE_BITS-1:0] lumbar;
    logic [SAMPLE_BITS-1:0] lft;
    logic [SAMPLE_BITS-1:0] rgt;
    pick_levels(seat, lumbar, lft, rgt);
    push_item(ACT_SAMPLE, seat, lumbar, lft, rgt);
  endtask

  // Stop offering and wait until every predicted report has transferred
  task automatic settle();
    in_if.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Write every register while idle; unused upper data bits carry noise
  task automatic apply_settings(input cfg_t s);
    settle();
    write_reg(CFG_SEAT_THR, ($urandom & 32'hFFFF_F000) | 32'(s.seat_thr));
    write_reg(CFG_LUMBAR_THR, ($urandom & 32'hFFFF_F000) | 32'(s.lumbar_thr));
    write_reg(CFG_SIDE_MIN, ($urandom & 32'hFFFF_E000) | 32'(s.side_min));
    write_reg(CFG_BALANCE_PCT, ($urandom & 32'hFFFF_FF80) | 32'(s.balance_pct));
    write_reg(CFG_BAD_LIMIT, s.bad_limit);
    write_reg(CFG_SIT_LIMIT, s.sit_limit);
    write_reg(CFG_REPORT_INT, s.report_int);
    write_reg(CFG_SPARE, $urandom);
    cfg_we_i <= 1'b0;
    cfg_now = s;
  endtask

  function automatic cfg_t draw_settings(input int unsigned phase);
    cfg_t s;
    s = '0;
    case (phase)
      0: ;
      1: begin
        s.seat_thr    = '1;
        s.lumbar_thr  = '1;
        s.side_min    = 13'd8190;
        s.balance_pct = 7'd100;
        s.bad_limit   = '1;
        s.sit_limit   = '1;
        s.report_int  = '1;
      end
      default: begin
        s.seat_thr    = LEVEL_THR_W'($urandom_range(200, 2000));
        s.lumbar_thr  = LEVEL_THR_W'($urandom_range(500, 3000));
        s.side_min    = SIDE_MIN_W'($urandom_range(0, 2000));
        s.balance_pct = PCT_W'($urandom_range(0, 100));
        s.bad_limit   = $urandom_range(0, 200);
        s.sit_limit   = (phase == 5) ? '1 : $urandom_range(0, 400);
        s.report_int  = $urandom_range(0, 300);
      end
    endcase
    return s;
  endfunction

  // Mix sample bursts and short tick bursts, counting every item sent
  task automatic run_phase(input int unsigned budget, input bit hold_midway,
                           input bit pause_midway);
    int unsigned done;
    int unsigned roll;
    int unsigned len;
    done = 0;
    while (done < budget) begin
      if (done >= budget / 2 && hold_midway) begin
        hold_midway = 1'b0;
        hold_reports = 1'b1;
        repeat (12) push_sample();
        done += 12;
      end
      if (done >= budget / 2 && pause_midway) begin
        pause_midway = 1'b0;
        settle();
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        len = $urandom_range(1, 4);
        repeat (len) push_sample();
        done += len;
      end else begin
        len = $urandom_range(1, 12);
        push_ticks(len);
        done += len;
      end
    end
  endtask

  initial begin : stimulus
    cfg_t s;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_SEAT_THR;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_TICK;
    in_if.seat_level   = '0;
    in_if.lumbar_level = '0;
    in_if.left_level   = '0;
    in_if.right_level  = '0;
    calm               = 1'b0;
    hold_reports       = 1'b0;
    cfg_now.seat_thr    = RST_SEAT_THR;
    cfg_now.lumbar_thr  = RST_LUMBAR_THR;
    cfg_now.side_min    = RST_SIDE_MIN;
    cfg_now.balance_pct = RST_BALANCE_PCT;
    cfg_now.bad_limit   = RST_BAD_LIMIT;
    cfg_now.sit_limit   = RST_SIT_LIMIT;
    cfg_now.report_int  = RST_REPORT_INT;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default registers: every class, threshold equality, lean boundary
    push_item(ACT_SAMPLE, 12'd0, 12'd0, 12'd0, 12'd0);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    push_ticks(3);
    push_item(ACT_SAMPLE, 12'd1000, 12'd2500, 12'd700, 12'd300);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd701, 12'd300);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd300, 12'd701);
    push_item(ACT_SAMPLE, 12'd999, 12'd4095, 12'd2000, 12'd2000);
    push_item(ACT_SAMPLE, 12'd1000, 12'd2499, 12'd2000, 12'd2000);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 12'd0);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd0, 12'd4095);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd400, 12'd399);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd400, 12'd400);

    // Zero limits and side minimum: the first sample sets the sitting alert
    s = '0;
    s.seat_thr   = RST_SEAT_THR;
    s.lumbar_thr = RST_LUMBAR_THR;
    apply_settings(s);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd0, 12'd0);
    push_ticks(2);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd5, 12'd4);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd4, 12'd5);
    push_item(ACT_SAMPLE, 12'd4095, 12'd4095, 12'd5, 12'd5);
    push_item(ACT_SAMPLE, 12'd4095, 12'd0, 12'd5, 12'd5);
    push_item(ACT_SAMPLE, 12'd0, 12'd4095, 12'd5, 12'd5);

    // Random phases across register settings
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      apply_settings(draw_settings(phase));
      calm = (phase == 3);
      run_phase(PHASE_ITEMS, phase == 2, phase == 4);
    end
    calm = 1'b0;

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS seat_pressure_posture_monitor_unit");
    end else begin
      $display("FAIL seat_pressure_posture_monitor_unit");
    end
    $finish;
  end

endmodule
